[design/eggd_pkg.sv]
// ---------------------------------------------------------------------------
// eggd_pkg: shared definitions for the egg drop solver
// Sizes, microcode step and condition codes, control word and the microcode
// program itself.
// ---------------------------------------------------------------------------
package eggd_pkg;

  localparam int MAX_EGGS   = 8;
  localparam int MAX_FLOORS = 255;

  localparam int EGG_IN_W   = 4;
  localparam int FLOOR_IN_W = 8;
  localparam int DATA_W     = 8;
  localparam int EGG_W      = $clog2(MAX_EGGS + 1);
  localparam int COL_W      = $clog2(MAX_FLOORS + 1);
  localparam int UPC_W      = 4;
  localparam int COND_W     = 3;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER      = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS     = 3'd1;
  localparam logic [COND_W-1:0] C_NOT_START  = 3'd2;
  localparam logic [COND_W-1:0] C_ZERO       = 3'd3;
  localparam logic [COND_W-1:0] C_F_NOT_DONE = 3'd4;
  localparam logic [COND_W-1:0] C_E_DONE     = 3'd5;
  localparam logic [COND_W-1:0] C_J_NOT_LAST = 3'd6;
  localparam logic [COND_W-1:0] C_OUT_BUSY   = 3'd7;

  // microcode steps
  localparam logic [UPC_W-1:0] S_IDLE    = 4'd0;
  localparam logic [UPC_W-1:0] S_ZCHK    = 4'd1;
  localparam logic [UPC_W-1:0] S_ROW1    = 4'd2;
  localparam logic [UPC_W-1:0] S_ROWEND  = 4'd3;
  localparam logic [UPC_W-1:0] S_JSTART  = 4'd4;
  localparam logic [UPC_W-1:0] S_JLOOP   = 4'd5;
  localparam logic [UPC_W-1:0] S_DRAIN   = 4'd6;
  localparam logic [UPC_W-1:0] S_WRBEST  = 4'd7;
  localparam logic [UPC_W-1:0] S_NEXTF   = 4'd8;
  localparam logic [UPC_W-1:0] S_FIN     = 4'd9;
  localparam logic [UPC_W-1:0] S_OUT     = 4'd10;
  localparam logic [UPC_W-1:0] S_OUTRET  = 4'd11;
  localparam logic [UPC_W-1:0] S_ZOUT    = 4'd12;
  localparam logic [UPC_W-1:0] S_ZOUTRET = 4'd13;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  target;
    logic              load;
    logic              wr_f;
    logic              wr_best;
    logic              f_inc;
    logic              f_init;
    logic              e_inc;
    logic              j_init;
    logic              best_init;
    logic              issue;
    logic              rd_final;
    logic              out_load;
    logic              out_zero;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic zero;
    logic f_done;
    logic e_done;
    logic j_last;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
    ctrl_t c;
    c = '0;
    case (upc)
      S_IDLE: begin
        c.load = 1'b1;
        c.cond = C_NOT_START;
        c.target = S_IDLE;
      end
      S_ZCHK: begin
        c.cond = C_ZERO;
        c.target = S_ZOUT;
      end
      S_ROW1: begin
        c.wr_f = 1'b1;
        c.f_inc = 1'b1;
        c.cond = C_F_NOT_DONE;
        c.target = S_ROW1;
      end
      S_ROWEND: begin
        c.e_inc = 1'b1;
        c.f_init = 1'b1;
        c.cond = C_E_DONE;
        c.target = S_FIN;
      end
      S_JSTART: begin
        c.j_init = 1'b1;
        c.best_init = 1'b1;
      end
      S_JLOOP: begin
        c.issue = 1'b1;
        c.cond = C_J_NOT_LAST;
        c.target = S_JLOOP;
      end
      S_DRAIN: begin
        c.cond = C_NEVER;
      end
      S_WRBEST: begin
        c.wr_best = 1'b1;
        c.f_inc = 1'b1;
        c.cond = C_F_NOT_DONE;
        c.target = S_JSTART;
      end
      S_NEXTF: begin
        c.cond = C_ALWAYS;
        c.target = S_ROWEND;
      end
      S_FIN: begin
        c.rd_final = 1'b1;
      end
      S_OUT: begin
        c.rd_final = 1'b1;
        c.out_load = 1'b1;
        c.cond = C_OUT_BUSY;
        c.target = S_OUT;
      end
      S_OUTRET: begin
        c.cond = C_ALWAYS;
        c.target = S_IDLE;
      end
      S_ZOUT: begin
        c.out_load = 1'b1;
        c.out_zero = 1'b1;
        c.cond = C_OUT_BUSY;
        c.target = S_ZOUT;
      end
      S_ZOUTRET: begin
        c.cond = C_ALWAYS;
        c.target = S_IDLE;
      end
      default: begin
        c.cond = C_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

[design/eggd_seq.sv]
// ---------------------------------------------------------------------------
// eggd_seq: microcode sequencer
// Step counter, control store lookup and conditional jump selection.
// ---------------------------------------------------------------------------
module eggd_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  eggd_pkg::stat_t             stat,
  output eggd_pkg::ctrl_t             ctrl
);

  logic [eggd_pkg::UPC_W-1:0] upc_r;
  logic [eggd_pkg::UPC_W-1:0] upc_nxt;
  logic                       take;

  assign ctrl = eggd_pkg::ucode(upc_r);

  always_comb begin
    case (ctrl.cond)
      eggd_pkg::C_NEVER:      take = 1'b0;
      eggd_pkg::C_ALWAYS:     take = 1'b1;
      eggd_pkg::C_NOT_START:  take = !stat.start;
      eggd_pkg::C_ZERO:       take = stat.zero;
      eggd_pkg::C_F_NOT_DONE: take = !stat.f_done;
      eggd_pkg::C_E_DONE:     take = stat.e_done;
      eggd_pkg::C_J_NOT_LAST: take = !stat.j_last;
      eggd_pkg::C_OUT_BUSY:   take = stat.out_busy;
      default:                take = 1'b0;
    endcase
    upc_nxt = take ? ctrl.target : upc_r + eggd_pkg::UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= eggd_pkg::S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[design/eggd_dp.sv]
// ---------------------------------------------------------------------------
// eggd_dp: table datapath
// Egg, floor and split counters, two-row table memory and the min-max unit.
// ---------------------------------------------------------------------------
module eggd_dp (
  input  logic                                clk,
  input  eggd_pkg::ctrl_t                     ctrl,
  input  logic [eggd_pkg::EGG_IN_W-1:0]       egg_count,
  input  logic [eggd_pkg::FLOOR_IN_W-1:0]     floor_count,
  output logic                                zero,
  output logic                                f_done,
  output logic                                e_done,
  output logic                                j_last,
  output logic [eggd_pkg::DATA_W-1:0]         result
);

  localparam int EW = eggd_pkg::EGG_W;
  localparam int CW = eggd_pkg::COL_W;
  localparam int DW = eggd_pkg::DATA_W;

  logic [EW-1:0] eggs_r;
  logic [CW-1:0] floors_r;
  logic [EW-1:0] e_r;
  logic [CW-1:0] f_r;
  logic [CW-1:0] j_r;
  logic [DW-1:0] best_r;
  logic [DW-1:0] rd_a_r;
  logic [DW-1:0] rd_b_r;
  logic          za_r;
  logic          zb_r;
  logic          cmp_v_r;
  logic [DW-1:0] mem_r [0:1][0:eggd_pkg::MAX_FLOORS];

  logic [EW-1:0] eggs_nxt;
  logic [CW-1:0] floors_nxt;
  logic          ra_row;
  logic [CW-1:0] ra_col;
  logic          rb_row;
  logic [CW-1:0] rb_col;
  logic          we;
  logic [DW-1:0] wd;
  logic [DW-1:0] a_val;
  logic [DW-1:0] b_val;
  logic [DW-1:0] worst;

  always_comb begin
    eggs_nxt = (32'(egg_count) > eggd_pkg::MAX_EGGS) ? EW'(eggd_pkg::MAX_EGGS)
                                                     : EW'(egg_count);
    floors_nxt = (32'(floor_count) > eggd_pkg::MAX_FLOORS)
                 ? CW'(eggd_pkg::MAX_FLOORS) : CW'(floor_count);
  end

  assign zero   = (eggs_r == '0) || (floors_r == '0);
  assign f_done = (f_r == floors_r);
  assign e_done = (e_r == eggs_r);
  assign j_last = (j_r == f_r - CW'(1));
  assign result = rd_a_r;

  always_comb begin
    if (ctrl.rd_final) begin
      ra_row = eggs_r[0];
      ra_col = floors_r;
    end else begin
      ra_row = e_r[0];
      ra_col = j_r;
    end
    rb_row = ~e_r[0];
    rb_col = f_r - j_r - CW'(1);
    we = ctrl.wr_f || ctrl.wr_best;
    wd = ctrl.wr_f ? DW'(f_r) : best_r + DW'(1);
    a_val = za_r ? '0 : rd_a_r;
    b_val = zb_r ? '0 : rd_b_r;
    worst = (a_val > b_val) ? a_val : b_val;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[e_r[0]][f_r] <= wd;
    end
    rd_a_r <= mem_r[ra_row][ra_col];
    rd_b_r <= mem_r[rb_row][rb_col];
    za_r <= (ra_col == '0);
    zb_r <= (rb_col == '0);
    cmp_v_r <= ctrl.issue;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      eggs_r <= eggs_nxt;
      floors_r <= floors_nxt;
      e_r <= EW'(1);
      f_r <= CW'(1);
    end else begin
      if (ctrl.e_inc) begin
        e_r <= e_r + EW'(1);
      end
      if (ctrl.f_init) begin
        f_r <= CW'(1);
      end else if (ctrl.f_inc) begin
        f_r <= f_r + CW'(1);
      end
    end
    if (ctrl.j_init) begin
      j_r <= '0;
    end else if (ctrl.issue) begin
      j_r <= j_r + CW'(1);
    end
    if (ctrl.best_init) begin
      best_r <= '1;
    end else if (cmp_v_r && (worst < best_r)) begin
      best_r <= worst;
    end
  end

endmodule

[design/egg_drop_min_trials.sv]
// The table datapath evaluates one split compare per cycle; zero eggs or zero
// floors skip the table and give a result of 0.
// Only one request is taken at a time; after the result is loaded into the output
// register, the sequencer passes through a return step before it takes the next.
// Reset clears the step counter and the output valid; the row store is not cleared.
// ---------------------------------------------------------------------------
// egg_drop_min_trials: worst-case minimum egg drops
// Microcoded sequencer over a two-row dynamic programming table.
// ---------------------------------------------------------------------------
module egg_drop_min_trials (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [eggd_pkg::EGG_IN_W-1:0]       in_egg_count,
  input  logic [eggd_pkg::FLOOR_IN_W-1:0]     in_floor_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [eggd_pkg::DATA_W-1:0]         out_min_drops
);

  eggd_pkg::ctrl_t              ctrl;
  eggd_pkg::stat_t              stat;
  logic                         out_valid_r;
  logic [eggd_pkg::DATA_W-1:0]  out_min_drops_r;
  logic [eggd_pkg::DATA_W-1:0]  result;
  logic                         out_free;
  logic                         zero;
  logic                         f_done;
  logic                         e_done;
  logic                         j_last;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = ctrl.load;
  assign out_valid = out_valid_r;
  assign out_min_drops = out_min_drops_r;

  always_comb begin
    stat.start = in_valid;
    stat.zero = zero;
    stat.f_done = f_done;
    stat.e_done = e_done;
    stat.j_last = j_last;
    stat.out_busy = !out_free;
  end

  eggd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  eggd_dp u_dp (
    .clk         (clk),
    .ctrl        (ctrl),
    .egg_count   (in_egg_count),
    .floor_count (in_floor_count),
    .zero        (zero),
    .f_done      (f_done),
    .e_done      (e_done),
    .j_last      (j_last),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && out_free) begin
      out_min_drops_r <= ctrl.out_zero ? '0 : result;
    end
  end

endmodule
